// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== design/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// shared types and constants of the box frustum cull test
// ----------------------------------------------------------------------------
package afc_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned PROD_W  = 2 * COORD_W;
   // three products plus the shifted offset, with headroom for the sign
   localparam int unsigned ACC_W   = PROD_W + 2;
   localparam int unsigned AXIS_W  = 2;

   // request tdata layout, lowest bit first
   localparam int unsigned REQ_TDATA_W = 328;
   localparam int unsigned OFS_IDX   = 0;
   localparam int unsigned OFS_A     = OFS_IDX + IDX_W;
   localparam int unsigned OFS_B     = OFS_A + COORD_W;
   localparam int unsigned OFS_C     = OFS_B + COORD_W;
   localparam int unsigned OFS_D     = OFS_C + COORD_W;
   localparam int unsigned OFS_MIN_X = OFS_D + COORD_W;
   localparam int unsigned OFS_MIN_Y = OFS_MIN_X + COORD_W;
   localparam int unsigned OFS_MIN_Z = OFS_MIN_Y + COORD_W;
   localparam int unsigned OFS_MAX_X = OFS_MIN_Z + COORD_W;
   localparam int unsigned OFS_MAX_Y = OFS_MAX_X + COORD_W;
   localparam int unsigned OFS_MAX_Z = OFS_MAX_Y + COORD_W;
   localparam int unsigned RSP_TDATA_W = 8;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_TEST = 1'b1
   } mode_type;

   typedef enum logic [AXIS_W-1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
      logic [COORD_W-1:0] c;
      logic [COORD_W-1:0] d;
   } plane_type;

   // control word travelling with each product through the shared unit
   typedef struct packed {
      logic clear;
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

// ===== design/afc_plane_store.sv =====
// ----------------------------------------------------------------------------
// afc_plane_store
// register file of frustum planes, one write port and one read port
// ----------------------------------------------------------------------------
module afc_plane_store #(
   parameter  int unsigned NUM_PLANES = 6,
   localparam int unsigned PIDX_W     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [afc_pkg::IDX_W-1:0]    wr_idx,
   input  afc_pkg::plane_type           wr_plane,
   input  logic [PIDX_W-1:0]            rd_idx,
   output afc_pkg::plane_type           rd_plane
);

   localparam int unsigned CMP_W  = 5;

   afc_pkg::plane_type planes_ff [NUM_PLANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            planes_ff[i] <= '0;
         end
      end else begin
         // out of range indexes match no entry and are dropped
         for (int i = 0; i < NUM_PLANES; i++) begin
            if (wr_en && (CMP_W'(wr_idx) == CMP_W'(i))) begin
               planes_ff[i] <= wr_plane;
            end
         end
      end
   end

   assign rd_plane = planes_ff[rd_idx];

endmodule

// ===== design/afc_mac_unit.sv =====
// ----------------------------------------------------------------------------
// afc_mac_unit
// shared multiply-accumulate unit: one product per cycle, plane sum sign test
// ----------------------------------------------------------------------------
module afc_mac_unit #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  afc_pkg::mac_ctl_type          ctl,
   input  logic [afc_pkg::COORD_W-1:0]   coef,
   input  logic [afc_pkg::COORD_W-1:0]   lo_coord,
   input  logic [afc_pkg::COORD_W-1:0]   hi_coord,
   input  logic [afc_pkg::COORD_W-1:0]   offset,
   output logic                          outside
);

   localparam int unsigned CW = afc_pkg::COORD_W;
   localparam int unsigned PW = afc_pkg::PROD_W;
   localparam int unsigned AW = afc_pkg::ACC_W;

   afc_pkg::mac_ctl_type ctl_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   logic [CW-1:0]        offs_ff;
   logic [CW-1:0]        corner;
   logic signed [AW-1:0] acc_ff;
   logic signed [AW-1:0] base;
   logic signed [AW-1:0] sum;
   logic                 outside_ff;
   logic                 positive;

   // near corner: min where the normal component is non-negative
   assign corner  = coef[CW-1] ? hi_coord : lo_coord;
   assign prod_in = $signed(coef) * $signed(corner);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      offs_ff <= offset;
   end

   assign base = ctl_ff.first
      ? ($signed({{(AW-CW){offs_ff[CW-1]}}, offs_ff}) <<< FRAC_BITS)
      : acc_ff;
   assign sum      = base + $signed({{(AW-PW){prod_ff[PW-1]}}, prod_ff});
   assign positive = !sum[AW-1] && (sum != '0);

   always_ff @(posedge clock) begin
      if (ctl_ff.valid) begin
         acc_ff <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outside_ff <= 1'b0;
      end else if (ctl.clear) begin
         outside_ff <= 1'b0;
      end else if (ctl_ff.valid && ctl_ff.last && positive) begin
         outside_ff <= 1'b1;
      end
   end

   assign outside = outside_ff;

endmodule

// ===== design/aabb_frustum_cull_test.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test
// box against frustum cull test, near-corner method, shared multiplier
// ----------------------------------------------------------------------------
// req channel: tuser is the item kind (0 load a plane, 1 test a box); tdata
// carries the plane index, the plane a,b,c,d and the box min and max corners.
// A load transfer writes one plane slot and gives no reply; an index at or
// above NUM_PLANES is dropped. Loads can follow back to back. A test
// transfer starts the sequencer: one signed 32x32 multiplier is used for
// every product, one product per cycle, three per plane, so a box runs
// through 3*NUM_PLANES multiplies (ST_RUN), then the accumulator drains
// (ST_DRAIN) and the reply is presented on rsp (ST_OUT). A new box is
// taken only once the block is back in ST_IDLE, after the reply is taken.
// rsp tdata bit 0 is inside_res (1 = keep, 0 = culled).
// While a reply waits for rsp_tready the block holds it stable and takes no
// new request; once taken, req_tready returns the next cycle.
// Reset clears all planes to zero (such planes never cull) and empties the
// sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aabb_frustum_cull_test #(
   parameter int unsigned NUM_PLANES = 6,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // plane_index, plane_a, plane_b, plane_c, plane_d, min_x, min_y, min_z,
   // max_x, max_y, max_z, zero pad
   input  logic [afc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // mode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // inside_res, zero pad
   output logic [afc_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int unsigned PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam int unsigned CW     = afc_pkg::COORD_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [PIDX_W-1:0]     plane_ff, plane_in;
   afc_pkg::axis_type     axis_ff, axis_in;
   logic [CW-1:0]         box_ff [6];
   logic                  req_xfer;
   logic                  test_start;
   logic                  load_wr;
   logic                  last_issue;
   afc_pkg::plane_type    wr_plane;
   afc_pkg::plane_type    rd_plane;
   afc_pkg::mac_ctl_type  ctl;
   logic [CW-1:0]         coef;
   logic [CW-1:0]         lo_coord;
   logic [CW-1:0]         hi_coord;
   logic                  outside;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign test_start = req_xfer && (req_tuser == afc_pkg::MODE_TEST);
   assign load_wr    = req_xfer && (req_tuser == afc_pkg::MODE_LOAD);

   assign wr_plane.a = req_tdata[afc_pkg::OFS_A +: CW];
   assign wr_plane.b = req_tdata[afc_pkg::OFS_B +: CW];
   assign wr_plane.c = req_tdata[afc_pkg::OFS_C +: CW];
   assign wr_plane.d = req_tdata[afc_pkg::OFS_D +: CW];

   // box corners: min x,y,z then max x,y,z
   always_ff @(posedge clock) begin
      if (test_start) begin
         box_ff[0] <= req_tdata[afc_pkg::OFS_MIN_X +: CW];
         box_ff[1] <= req_tdata[afc_pkg::OFS_MIN_Y +: CW];
         box_ff[2] <= req_tdata[afc_pkg::OFS_MIN_Z +: CW];
         box_ff[3] <= req_tdata[afc_pkg::OFS_MAX_X +: CW];
         box_ff[4] <= req_tdata[afc_pkg::OFS_MAX_Y +: CW];
         box_ff[5] <= req_tdata[afc_pkg::OFS_MAX_Z +: CW];
      end
   end

   afc_plane_store #(
      .NUM_PLANES (NUM_PLANES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load_wr),
      .wr_idx   (req_tdata[afc_pkg::OFS_IDX +: afc_pkg::IDX_W]),
      .wr_plane (wr_plane),
      .rd_idx   (plane_ff),
      .rd_plane (rd_plane)
   );

   assign last_issue = (plane_ff == PIDX_W'(NUM_PLANES - 1))
                       && (axis_ff == afc_pkg::AXIS_Z);

   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (test_start) begin
               state_in = ST_RUN;
               plane_in = '0;
               axis_in  = afc_pkg::AXIS_X;
            end
         end
         ST_RUN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end else if (axis_ff == afc_pkg::AXIS_Z) begin
               axis_in  = afc_pkg::AXIS_X;
               plane_in = plane_ff + 1'b1;
            end else begin
               axis_in  = afc_pkg::axis_type'(axis_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         plane_ff <= '0;
         axis_ff  <= afc_pkg::AXIS_X;
      end else begin
         state_ff <= state_in;
         plane_ff <= plane_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      unique case (axis_ff)
         afc_pkg::AXIS_X: begin
            coef     = rd_plane.a;
            lo_coord = box_ff[0];
            hi_coord = box_ff[3];
         end
         afc_pkg::AXIS_Y: begin
            coef     = rd_plane.b;
            lo_coord = box_ff[1];
            hi_coord = box_ff[4];
         end
         default: begin
            coef     = rd_plane.c;
            lo_coord = box_ff[2];
            hi_coord = box_ff[5];
         end
      endcase
   end

   assign ctl.clear = test_start;
   assign ctl.valid = (state_ff == ST_RUN);
   assign ctl.first = (axis_ff == afc_pkg::AXIS_X);
   assign ctl.last  = (axis_ff == afc_pkg::AXIS_Z);

   afc_mac_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .coef     (coef),
      .lo_coord (lo_coord),
      .hi_coord (hi_coord),
      .offset   (rd_plane.d),
      .outside  (outside)
   );

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {{(afc_pkg::RSP_TDATA_W-1){1'b0}}, !outside};

   `ASSERT_NEVER(a_no_req_while_rsp, clock, reset, rsp_tvalid && req_tready)
   `ASSERT_PROP(a_test_starts_run, clock, reset, test_start |=> (state_ff == ST_RUN))
   `ASSERT_PROP(a_rsp_after_drain, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff == ST_DRAIN))
   `ASSERT_PROP(a_run_ends_in_drain, clock, reset, (state_ff == ST_RUN) && last_issue |=> (state_ff == ST_DRAIN))

endmodule
